>>> src/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only while reset is released.
`define ASSERT_RUN(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

>>> src/fdep_pkg.sv
// Package for the FAT directory entry parser: word types, codes and helpers.
// Depends on nothing; used by every module of the block except fdep_ram.
package fdep_pkg;

    localparam int MAX_ENTRIES_DEF     = 128;
    localparam int LONG_NAME_SLOTS_DEF = 20;
    localparam int NAME_BUFFER_DEF     = 256;

    localparam int CHARS_PER_SLOT = 13;
    localparam int ROW_BITS       = CHARS_PER_SLOT * 8;

    localparam logic [7:0]  B0_END      = 8'h00;
    localparam logic [7:0]  B0_DELETED  = 8'hE5;
    localparam logic [7:0]  ATTR_LFN    = 8'h0F;
    localparam logic [7:0]  SEQ_MASK    = 8'h1F;
    localparam logic [7:0]  LFN_FIRST   = 8'h40;
    localparam logic [7:0]  ATTR_LABEL  = 8'h08;
    localparam logic [7:0]  CH_SPACE    = 8'h20;
    localparam logic [7:0]  CH_DOT      = 8'h2E;
    localparam logic [7:0]  CH_UNDER    = 8'h5F;
    localparam logic [15:0] CH_PAD      = 16'hFFFF;

    localparam logic [1:0] RK_HEADER = 2'd0;
    localparam logic [1:0] RK_CHUNK  = 2'd1;
    localparam logic [1:0] RK_END    = 2'd2;

    typedef struct packed {
        logic        first_of_directory;
        logic [63:0] entry_bytes_0_7;
        logic [63:0] entry_bytes_8_15;
        logic [63:0] entry_bytes_16_23;
        logic [63:0] entry_bytes_24_31;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [6:0]  entry_index;
        logic        is_directory;
        logic [31:0] start_cluster;
        logic [31:0] byte_size;
        logic [7:0]  name_length;
        logic        used_long_name;
        logic [63:0] name_chunk;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        EK_END     = 3'd0,
        EK_DELETED = 3'd1,
        EK_LFN     = 3'd2,
        EK_SKIP    = 3'd3,
        EK_REGULAR = 3'd4
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t  kind;
        logic         first;
        logic [255:0] bytes;
    } cmd_t;

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    // Byte offset of the i-th UTF-16 character inside a long-name piece.
    function automatic int lfn_offset(input int i);
        int off;
        unique case (i)
            0: off = 1;
            1: off = 3;
            2: off = 5;
            3: off = 7;
            4: off = 9;
            5: off = 14;
            6: off = 16;
            7: off = 18;
            8: off = 20;
            9: off = 22;
            10: off = 24;
            11: off = 28;
            default: off = 30;
        endcase
        return off;
    endfunction

endpackage

>>> src/fat_directory_entry_parser_top.sv
// FAT directory entry parser, top level. The back end walks a regular entry's name one
// character per cycle in its step state, once to measure it and once to fill chunks,
// leaving that state to send the header and each chunk word.
// Synchronous active-low reset clears all scan state and the store's row valid bits
// at once, so no clearing pass is needed. Depends on fdep_pkg, fdep_front, fdep_back.
module fat_directory_entry_parser_top #(
    parameter int MAX_ENTRIES     = fdep_pkg::MAX_ENTRIES_DEF,
    parameter int LONG_NAME_SLOTS = fdep_pkg::LONG_NAME_SLOTS_DEF,
    parameter int NAME_BUFFER     = fdep_pkg::NAME_BUFFER_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  fdep_pkg::in_item_t  s_data,
    input  logic                s_valid,
    output logic                s_ready,
    output fdep_pkg::out_item_t m_data,
    output logic                m_valid,
    input  logic                m_ready
);
    import fdep_pkg::*;

    // The front end classifies each incoming word and holds up to two
    // commands, so the source can keep delivering while a name drains.
    cmd_t q_cmd;
    logic q_valid;
    logic q_pop;

    fdep_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .q_cmd   (q_cmd),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    // The back end owns the scan state and the long-name store and
    // drives the registered result word.
    fdep_back #(
        .MAX_ENTRIES     (MAX_ENTRIES),
        .LONG_NAME_SLOTS (LONG_NAME_SLOTS),
        .NAME_BUFFER     (NAME_BUFFER)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_cmd   (q_cmd),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );
endmodule

>>> src/fdep_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module fdep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end
endmodule

>>> src/fdep_front.sv
// Front end: takes input words, classifies each entry, queues commands.
// Depends on fdep_pkg.
module fdep_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  fdep_pkg::in_item_t s_data,
    input  logic              s_valid,
    output logic              s_ready,
    output fdep_pkg::cmd_t    q_cmd,
    output logic              q_valid,
    input  logic              q_pop
);
    import fdep_pkg::*;

    cmd_t        mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    cmd_t        in_cmd;
    logic [7:0]  b0, attr;
    logic        push, pop;

    always_comb begin
        in_cmd.first = s_data.first_of_directory;
        in_cmd.bytes = {s_data.entry_bytes_24_31, s_data.entry_bytes_16_23,
                        s_data.entry_bytes_8_15, s_data.entry_bytes_0_7};
        b0   = in_cmd.bytes[7:0];
        attr = in_cmd.bytes[95:88];
        priority if (b0 == B0_END) begin
            in_cmd.kind = EK_END;
        end else if (b0 == B0_DELETED) begin
            in_cmd.kind = EK_DELETED;
        end else if (attr == ATTR_LFN) begin
            in_cmd.kind = EK_LFN;
        end else if ((attr & ATTR_LABEL) != 8'd0 || b0 == CH_DOT) begin
            in_cmd.kind = EK_SKIP;
        end else begin
            in_cmd.kind = EK_REGULAR;
        end
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end
endmodule

>>> src/fdep_back.sv
// Back end: scan state, long-name store and result sequencing.
// Depends on fdep_pkg and fdep_ram.
module fdep_back #(
    parameter int MAX_ENTRIES     = fdep_pkg::MAX_ENTRIES_DEF,
    parameter int LONG_NAME_SLOTS = fdep_pkg::LONG_NAME_SLOTS_DEF,
    parameter int NAME_BUFFER     = fdep_pkg::NAME_BUFFER_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  fdep_pkg::cmd_t     q_cmd,
    input  logic               q_valid,
    output logic               q_pop,
    output fdep_pkg::out_item_t m_data,
    output logic               m_valid,
    input  logic               m_ready
);
    import fdep_pkg::*;

    localparam int AW    = (LONG_NAME_SLOTS > 1) ? $clog2(LONG_NAME_SLOTS) : 1;
    localparam int ROW_W = $clog2(LONG_NAME_SLOTS + 1);
    localparam logic [7:0] NAME_MAX = 8'(NAME_BUFFER - 1);
    localparam logic [7:0] COUNT_MAX = 8'(MAX_ENTRIES);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LFN_WR = 5'b00010,
        ST_STEP   = 5'b00100,
        ST_HDR    = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [7:0]           count_reg, count_next;
    logic                 done_reg, done_next;
    logic                 active_reg, active_next;
    logic [LONG_NAME_SLOTS-1:0] valid_reg, valid_next;
    logic                 src_long_reg, src_long_next;
    logic                 phase_reg, phase_next;
    logic [7:0]           len_reg, len_next;
    logic [7:0]           sent_reg, sent_next;
    logic [ROW_W-1:0]     row_reg, row_next, row_inc;
    logic [3:0]           col_reg, col_next;
    logic [3:0]           k_reg, k_next;
    logic [2:0]           fill_reg, fill_next;
    logic [63:0]          chunk_reg, chunk_next;
    out_item_t            out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 ram_wr_en, ram_rd_en;
    logic [AW-1:0]        ram_wr_addr, ram_rd_addr;
    logic [ROW_BITS-1:0]  ram_wr_data, ram_rd_data;

    logic [7:0]           eff_count;
    logic                 eff_done, eff_active, first_piece, slot_free, row_ok;
    logic [LONG_NAME_SLOTS-1:0] eff_valid;
    logic [7:0]           qb0;
    logic [4:0]           seq;
    logic [7:0]           c, sb, attr;
    logic                 skip, at_end, stop;
    logic [15:0]          ch;
    logic [3:0]           k_m1;

    fdep_ram #(.WIDTH(ROW_BITS), .DEPTH(LONG_NAME_SLOTS), .AW(AW)) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_data  = out_reg;
    assign m_valid = out_valid_reg;

    always_comb begin
        qb0        = q_cmd.bytes[7:0];
        seq        = qb0[4:0] & SEQ_MASK[4:0];
        first_piece = (qb0 & LFN_FIRST) != 8'd0;
        eff_count  = q_cmd.first ? 8'd0 : count_reg;
        eff_done   = q_cmd.first ? 1'b0 : done_reg;
        eff_active = q_cmd.first ? 1'b0 : active_reg;
        eff_valid  = q_cmd.first ? '0 : valid_reg;
        slot_free  = !out_valid_reg || m_ready;
        attr       = cmd_reg.bytes[95:88];
        row_inc    = row_reg + ROW_W'(1);
        k_m1       = k_reg - 4'd1;

        // Store entries outside the written rows read as zero.
        row_ok = 1'b0;
        for (int j = 0; j < LONG_NAME_SLOTS; j++) begin
            if (row_reg == ROW_W'(j) && valid_reg[j]) begin
                row_ok = 1'b1;
            end
        end

        // Current name character from the long-name store or the 8.3 name.
        skip   = 1'b0;
        at_end = 1'b0;
        c      = 8'd0;
        sb     = 8'd0;
        if (src_long_reg) begin
            c      = row_ok ? ram_rd_data[{col_reg, 3'b000} +: 8] : 8'd0;
            at_end = (c == 8'd0) || (len_reg == NAME_MAX);
        end else if (k_reg < 4'd8) begin
            sb     = cmd_reg.bytes[{k_reg, 3'b000} +: 8];
            skip   = (sb == CH_SPACE);
            c      = lower_ascii(sb);
            at_end = (sb == 8'd0);
        end else if (k_reg == 4'd8) begin
            at_end = (cmd_reg.bytes[71:64] == CH_SPACE);
            c      = CH_DOT;
        end else if (k_reg < 4'd12) begin
            sb     = cmd_reg.bytes[{k_m1, 3'b000} +: 8];
            skip   = (sb == CH_SPACE);
            c      = lower_ascii(sb);
            at_end = (sb == 8'd0);
        end else begin
            at_end = 1'b1;
        end

        // Merge of a long-name piece into its row.
        stop        = 1'b0;
        ram_wr_data = '0;
        for (int i = 0; i < CHARS_PER_SLOT; i++) begin
            ch = {cmd_reg.bytes[(lfn_offset(i) + 1) * 8 +: 8],
                  cmd_reg.bytes[lfn_offset(i) * 8 +: 8]};
            if (ch == 16'd0 || ch == CH_PAD) begin
                stop = 1'b1;
            end
            if (!stop) begin
                ram_wr_data[i*8 +: 8] = (ch < 16'd128) ? ch[7:0] : CH_UNDER;
            end else begin
                ram_wr_data[i*8 +: 8] = row_ok ? ram_rd_data[i*8 +: 8] : 8'd0;
            end
        end

        state_next     = state_reg;
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        done_next      = done_reg;
        active_next    = active_reg;
        valid_next     = valid_reg;
        src_long_next  = src_long_reg;
        phase_next     = phase_reg;
        len_next       = len_reg;
        sent_next      = sent_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        k_next         = k_reg;
        fill_next      = fill_reg;
        chunk_next     = chunk_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        q_pop          = 1'b0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = row_reg[AW-1:0];
        ram_wr_en      = 1'b0;
        ram_wr_addr    = row_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (eff_done || eff_count >= COUNT_MAX) begin
                        q_pop       = 1'b1;
                        count_next  = eff_count;
                        done_next   = eff_done;
                        active_next = eff_active;
                        valid_next  = eff_valid;
                    end else begin
                        unique case (q_cmd.kind)
                            EK_END: begin
                                if (slot_free) begin
                                    q_pop          = 1'b1;
                                    count_next     = eff_count;
                                    done_next      = 1'b1;
                                    active_next    = eff_active;
                                    valid_next     = eff_valid;
                                    out_next       = '0;
                                    out_next.result_kind = RK_END;
                                    out_next.entry_index = eff_count[6:0];
                                    out_next.last  = 1'b1;
                                    out_valid_next = 1'b1;
                                end
                            end
                            EK_DELETED, EK_SKIP: begin
                                q_pop       = 1'b1;
                                count_next  = eff_count;
                                done_next   = eff_done;
                                active_next = 1'b0;
                                valid_next  = eff_valid;
                            end
                            EK_LFN: begin
                                q_pop       = 1'b1;
                                count_next  = eff_count;
                                done_next   = eff_done;
                                active_next = first_piece ? 1'b1 : eff_active;
                                valid_next  = first_piece ? '0 : eff_valid;
                                cmd_next    = q_cmd;
                                if ((first_piece || eff_active) && seq != 5'd0 &&
                                    int'(seq) <= LONG_NAME_SLOTS) begin
                                    ram_rd_en   = 1'b1;
                                    ram_rd_addr = AW'(seq - 5'd1);
                                    row_next    = ROW_W'(seq - 5'd1);
                                    state_next  = ST_LFN_WR;
                                end
                            end
                            EK_REGULAR: begin
                                q_pop         = 1'b1;
                                count_next    = eff_count;
                                done_next     = eff_done;
                                active_next   = 1'b0;
                                valid_next    = eff_valid;
                                cmd_next      = q_cmd;
                                src_long_next = eff_active;
                                phase_next    = 1'b0;
                                len_next      = 8'd0;
                                row_next      = '0;
                                col_next      = 4'd0;
                                k_next        = 4'd0;
                                ram_rd_en     = 1'b1;
                                ram_rd_addr   = '0;
                                state_next    = ST_STEP;
                            end
                            default: begin
                                q_pop = 1'b1;
                            end
                        endcase
                    end
                end
            end
            ST_LFN_WR: begin
                ram_wr_en = 1'b1;
                for (int j = 0; j < LONG_NAME_SLOTS; j++) begin
                    if (row_reg == ROW_W'(j)) begin
                        valid_next[j] = 1'b1;
                    end
                end
                state_next = ST_IDLE;
            end
            ST_STEP: begin
                if (!phase_reg && at_end) begin
                    if (src_long_reg && len_reg == 8'd0) begin
                        // Empty long name: fall back to the 8.3 name.
                        src_long_next = 1'b0;
                        k_next        = 4'd0;
                    end else begin
                        state_next = ST_HDR;
                    end
                end else begin
                    if (!skip) begin
                        if (!phase_reg) begin
                            len_next = len_reg + 8'd1;
                        end else begin
                            for (int j = 0; j < 8; j++) begin
                                if (fill_reg == 3'(j)) begin
                                    chunk_next[j*8 +: 8] = c;
                                end
                            end
                            sent_next = sent_reg + 8'd1;
                            fill_next = fill_reg + 3'd1;
                            if (fill_reg == 3'd7 || sent_reg + 8'd1 == len_reg) begin
                                state_next = ST_EMIT;
                            end
                        end
                    end
                    if (src_long_reg) begin
                        if (col_reg == 4'(CHARS_PER_SLOT - 1)) begin
                            col_next    = 4'd0;
                            row_next    = row_inc;
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = row_inc[AW-1:0];
                        end else begin
                            col_next = col_reg + 4'd1;
                        end
                    end else begin
                        k_next = k_reg + 4'd1;
                    end
                end
            end
            ST_HDR: begin
                if (slot_free) begin
                    out_next                = '0;
                    out_next.result_kind    = RK_HEADER;
                    out_next.entry_index    = count_reg[6:0];
                    out_next.is_directory   = attr[4];
                    out_next.start_cluster  = {cmd_reg.bytes[175:160], cmd_reg.bytes[223:208]};
                    out_next.byte_size      = cmd_reg.bytes[255:224];
                    out_next.name_length    = len_reg;
                    out_next.used_long_name = src_long_reg;
                    out_next.last           = (len_reg == 8'd0);
                    out_valid_next          = 1'b1;
                    if (len_reg == 8'd0) begin
                        count_next = count_reg + 8'd1;
                        state_next = ST_IDLE;
                    end else begin
                        phase_next = 1'b1;
                        sent_next  = 8'd0;
                        fill_next  = 3'd0;
                        chunk_next = '0;
                        row_next   = '0;
                        col_next   = 4'd0;
                        k_next     = 4'd0;
                        ram_rd_en  = src_long_reg;
                        ram_rd_addr = '0;
                        state_next = ST_STEP;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    out_next             = '0;
                    out_next.result_kind = RK_CHUNK;
                    out_next.entry_index = count_reg[6:0];
                    out_next.name_chunk  = chunk_reg;
                    out_next.last        = (sent_reg == len_reg);
                    out_valid_next       = 1'b1;
                    chunk_next           = '0;
                    fill_next            = 3'd0;
                    if (sent_reg == len_reg) begin
                        count_next = count_reg + 8'd1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_STEP;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= 8'd0;
            done_reg      <= 1'b0;
            active_reg    <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            active_reg    <= active_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        src_long_reg <= src_long_next;
        phase_reg    <= phase_next;
        len_reg      <= len_next;
        sent_reg     <= sent_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        k_reg        <= k_next;
        fill_reg     <= fill_next;
        chunk_reg    <= chunk_next;
        out_reg      <= out_next;
    end
endmodule

>>> src/fdep_checker.sv
// Port-level checker for the FAT directory entry parser, bound to the top.
// Depends on fdep_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fdep_checker (
    input logic                aclk,
    input logic                aresetn,
    input fdep_pkg::in_item_t  s_data,
    input logic                s_valid,
    input logic                s_ready,
    input fdep_pkg::out_item_t m_data,
    input logic                m_valid,
    input logic                m_ready
);
    import fdep_pkg::*;

    `ASSERT_RUN(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result word changed while stalled")
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")
    `ASSERT_RUN(a_end_last, aclk, aresetn, m_valid && m_data.result_kind == RK_END |-> m_data.last && m_data.name_length == 8'd0, "end word malformed")
    `ASSERT_RUN(a_chunk_follows, aclk, aresetn, m_valid && m_ready && m_data.result_kind == RK_CHUNK && !m_data.last |=> !m_valid || m_data.result_kind == RK_CHUNK, "name chunks interrupted")
endmodule

bind fat_directory_entry_parser_top fdep_checker u_fdep_checker (.*);

>>> tb/sv/tb.sv
// Self-checking testbench for the FAT directory entry parser top level.
// Depends on fdep_pkg and fat_directory_entry_parser_top; needs nothing else.
`timescale 1ns / 1ps

module tb;
    import fdep_pkg::*;

    // Cycles without any accepted word before the run is declared hung. The slowest
    // entry gives 33 result words, and the receiver may stall before each of them.
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES   = 700;
    localparam int TARGET_ITEMS   = 280;
    localparam int LIST_MAX       = 128;
    localparam int SLOT_MAX       = 20;
    localparam int NAME_MAX       = 256;

    logic      aclk;
    logic      aresetn;
    in_item_t  s_data;
    logic      s_valid;
    logic      s_ready;
    out_item_t m_data;
    logic      m_valid;
    logic      m_ready;

    fat_directory_entry_parser_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_data(s_data), .s_valid(s_valid), .s_ready(s_ready),
        .m_data(m_data), .m_valid(m_valid), .m_ready(m_ready)
    );

    // Mirror of the parser state, updated as each entry word is accepted.
    logic [7:0] name_store [0:259];
    bit         lfn_open;
    int         dir_count;
    bit         dir_ended;

    // Words the parser still owes us, oldest first.
    out_item_t  pending_words[$];
    int         errors;
    int         items_sent;
    int         idle_cycles;

    // Byte positions of the 13 UTF-16 characters inside a long-name piece.
    int char_pos [0:12] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};

    // One row of the directed table. A typed row carries the one word it must give.
    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    dir_row_t directed_rows[$];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic void clear_scan();
        foreach (name_store[k]) name_store[k] = 8'h00;
        lfn_open  = 1'b0;
        dir_count = 0;
        dir_ended = 1'b0;
    endfunction

    // Works out the words one accepted entry causes, and advances the mirrored state.
    task automatic parse_entry(input in_item_t it, ref out_item_t words[$]);
        logic [255:0] v;
        logic [7:0]   b0, attr, c;
        logic [15:0]  ch;
        logic [7:0]   nm [0:255];
        logic [7:0]   tmp [0:11];
        int           len, j, seq, base, chunks;
        bit           from_lfn;
        out_item_t    w;
        v = {it.entry_bytes_24_31, it.entry_bytes_16_23, it.entry_bytes_8_15,
             it.entry_bytes_0_7};
        if (it.first_of_directory) clear_scan();
        if (dir_ended || dir_count >= LIST_MAX) return;
        b0   = v[7:0];
        attr = v[95:88];
        if (b0 == B0_END) begin
            dir_ended = 1'b1;
            w = '0;
            w.result_kind = RK_END;
            w.entry_index = dir_count[6:0];
            w.last = 1'b1;
            words.push_back(w);
            return;
        end
        if (b0 == B0_DELETED) begin
            lfn_open = 1'b0;
            return;
        end
        if (attr == ATTR_LFN) begin
            seq = b0 & 8'h1F;
            if (b0 & 8'h40) begin
                foreach (name_store[k]) name_store[k] = 8'h00;
                lfn_open = 1'b1;
            end
            if (lfn_open && seq >= 1 && seq <= SLOT_MAX) begin
                base = (seq - 1) * 13;
                for (int i = 0; i < 13; i++) begin
                    ch = v[char_pos[i]*8 +: 16];
                    if (ch == 16'h0000 || ch == 16'hFFFF) break;
                    if (base + i < 260) name_store[base + i] = (ch < 128) ? ch[7:0] : "_";
                end
            end
            return;
        end
        if ((attr & 8'h08) || b0 == ".") begin
            lfn_open = 1'b0;
            return;
        end
        len = 0;
        from_lfn = lfn_open && name_store[0] != 8'h00;
        if (from_lfn) begin
            while (len < NAME_MAX - 1 && name_store[len] != 8'h00) begin
                nm[len] = name_store[len];
                len++;
            end
        end else begin
            j = 0;
            for (int i = 0; i < 8; i++) begin
                c = v[i*8 +: 8];
                if (c != " ") begin
                    tmp[j] = fold_case(c);
                    j++;
                end
            end
            if (v[71:64] != " ") begin
                tmp[j] = ".";
                j++;
                for (int i = 8; i < 11; i++) begin
                    c = v[i*8 +: 8];
                    if (c != " ") begin
                        tmp[j] = fold_case(c);
                        j++;
                    end
                end
            end
            // A zero byte ends the short name early.
            while (len < j && tmp[len] != 8'h00) begin
                nm[len] = tmp[len];
                len++;
            end
        end
        lfn_open = 1'b0;
        chunks = (len + 7) / 8;
        w = '0;
        w.result_kind    = RK_HEADER;
        w.entry_index    = dir_count[6:0];
        w.is_directory   = attr[4];
        w.start_cluster  = {v[175:160], v[223:208]};
        w.byte_size      = v[255:224];
        w.name_length    = len[7:0];
        w.used_long_name = from_lfn;
        w.last           = (chunks == 0);
        words.push_back(w);
        for (int i = 0; i < chunks; i++) begin
            w = '0;
            w.result_kind = RK_CHUNK;
            w.entry_index = dir_count[6:0];
            for (int k = 0; k < 8; k++)
                if (i*8 + k < len) w.name_chunk[k*8 +: 8] = nm[i*8 + k];
            w.last = (i + 1 == chunks);
            words.push_back(w);
        end
        dir_count++;
    endtask

    function automatic in_item_t pack_entry(input logic [255:0] v, input bit first);
        in_item_t it;
        it.first_of_directory = first;
        it.entry_bytes_0_7    = v[63:0];
        it.entry_bytes_8_15   = v[127:64];
        it.entry_bytes_16_23  = v[191:128];
        it.entry_bytes_24_31  = v[255:192];
        return it;
    endfunction

    // Short entry: 11 name bytes as a string, attribute, first cluster and size.
    function automatic logic [255:0] short_entry(input string nm11, input logic [7:0] attr,
                                                 input logic [31:0] clus,
                                                 input logic [31:0] size);
        logic [255:0] v;
        v = '0;
        for (int i = 0; i < 11; i++) v[i*8 +: 8] = (i < nm11.len()) ? nm11[i] : " ";
        v[95:88]   = attr;
        v[175:160] = clus[31:16];
        v[223:208] = clus[15:0];
        v[255:224] = size;
        return v;
    endfunction

    // Long-name piece: sequence byte and 13 characters, character i at chars[16*i].
    function automatic logic [255:0] lfn_entry(input logic [7:0] seq_byte,
                                               input logic [207:0] chars);
        logic [255:0] v;
        v = '0;
        v[7:0]   = seq_byte;
        v[95:88] = ATTR_LFN;
        for (int i = 0; i < 13; i++) v[char_pos[i]*8 +: 16] = chars[i*16 +: 16];
        return v;
    endfunction

    // Text as UTF-16, one zero after it and padding after that.
    function automatic logic [207:0] utf16_of(input string s);
        logic [207:0] c;
        for (int i = 0; i < 13; i++)
            c[i*16 +: 16] = (i < s.len()) ? {8'h00, s[i]} :
                            (i == s.len()) ? 16'h0000 : CH_PAD;
        return c;
    endfunction

    function automatic logic [15:0] random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return 16'($urandom_range(32, 126));
        if (r < 93) return 16'($urandom_range(128, 65534));
        if (r < 96) return 16'h0000;
        return CH_PAD;
    endfunction

    function automatic logic [207:0] random_chars();
        logic [207:0] c;
        for (int i = 0; i < 13; i++) c[i*16 +: 16] = random_char();
        return c;
    endfunction

    function automatic logic [255:0] random_short(input bit plain);
        logic [255:0] v;
        string        pool;
        pool = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789  ~_-";
        v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        for (int i = 0; i < 11; i++)
            if (plain || $urandom_range(0, 9) != 0)
                v[i*8 +: 8] = pool[$urandom_range(0, pool.len() - 1)];
        if (v[7:0] == " " || v[7:0] == ".") v[7:0] = "F";
        case ($urandom_range(0, 3))
            0: v[95:88] = 8'h00;
            1: v[95:88] = 8'h10;
            2: v[95:88] = 8'h20;
            default: v[95:88] = 8'($urandom) & ~ATTR_LABEL;
        endcase
        return v;
    endfunction

    // Hands one entry word to the parser after a random gap unless no_gap is set, starting from a falling edge.
    task automatic send_entry(input in_item_t it, input bit typed, input out_item_t want,
                              input bit no_gap);
        int         gap;
        out_item_t  words[$];
        gap = no_gap ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        parse_entry(it, words);
        if (typed) pending_words.push_back(want);
        else foreach (words[k]) pending_words.push_back(words[k]);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_random(input in_item_t it, input bit no_gap);
        send_entry(it, 1'b0, '0, no_gap);
    endtask

    function automatic out_item_t end_word(input int idx);
        out_item_t w;
        w = '0;
        w.result_kind = RK_END;
        w.entry_index = idx[6:0];
        w.last = 1'b1;
        return w;
    endfunction

    task automatic add_row(input logic [255:0] v, input bit first);
        dir_row_t r;
        r.item  = pack_entry(v, first);
        r.typed = 1'b0;
        r.want  = '0;
        directed_rows.push_back(r);
    endtask

    task automatic add_typed(input logic [255:0] v, input bit first, input out_item_t want);
        dir_row_t r;
        r.item  = pack_entry(v, first);
        r.typed = 1'b1;
        r.want  = want;
        directed_rows.push_back(r);
    endtask

    // Result side: each word is checked field by field against the oldest expectation.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected result word kind=%0d", m_data.result_kind);
                errors++;
            end else begin
                want = pending_words.pop_front();
                if (m_data.result_kind !== want.result_kind) begin
                    $error("result_kind expected %0d got %0d", want.result_kind,
                           m_data.result_kind);
                    errors++;
                end
                if (m_data.entry_index !== want.entry_index) begin
                    $error("entry_index expected %0d got %0d", want.entry_index,
                           m_data.entry_index);
                    errors++;
                end
                if (m_data.is_directory !== want.is_directory) begin
                    $error("is_directory expected %0d got %0d", want.is_directory,
                           m_data.is_directory);
                    errors++;
                end
                if (m_data.start_cluster !== want.start_cluster) begin
                    $error("start_cluster expected %h got %h", want.start_cluster,
                           m_data.start_cluster);
                    errors++;
                end
                if (m_data.byte_size !== want.byte_size) begin
                    $error("byte_size expected %h got %h", want.byte_size, m_data.byte_size);
                    errors++;
                end
                if (m_data.name_length !== want.name_length) begin
                    $error("name_length expected %0d got %0d", want.name_length,
                           m_data.name_length);
                    errors++;
                end
                if (m_data.used_long_name !== want.used_long_name) begin
                    $error("used_long_name expected %0d got %0d", want.used_long_name,
                           m_data.used_long_name);
                    errors++;
                end
                if (m_data.name_chunk !== want.name_chunk) begin
                    $error("name_chunk expected %h got %h", want.name_chunk,
                           m_data.name_chunk);
                    errors++;
                end
                if (m_data.last !== want.last) begin
                    $error("last expected %0d got %0d", want.last, m_data.last);
                    errors++;
                end
            end
        end
    end

    // The receiver stalls a random number of cycles before each word, with calm stretches.
    initial begin
        int stall;
        bit calm;
        m_ready = 1'b0;
        calm = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 31) == 0) calm = ~calm;
            stall = calm ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Watchdog: a run with no accepted word for too long is hung.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        logic [255:0] v;
        logic [207:0] c;
        int           pieces, pick;
        bit           calm;
        errors      = 0;
        items_sent  = 0;
        idle_cycles = 0;
        s_valid     = 1'b0;
        s_data      = '0;
        aresetn     = 1'b0;
        clear_scan();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table. An end marker right after reset reports index zero.
        add_typed('0, 1'b0, end_word(0));
        // Once the directory has ended, entries are ignored until a restart.
        add_row(short_entry("IGNORED TXT", 8'h20, 32'h1, 32'h1), 1'b0);
        // Restart with a plain file carrying the largest cluster and size.
        add_row(short_entry("README  TXT", 8'h20, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1);
        // Directory without extension, then a name with no characters at all.
        add_row(short_entry("SUBDIR     ", 8'h10, 32'h0, 32'h0), 1'b0);
        v = short_entry("           ", 8'h00, 32'h1234_5678, 32'h9ABC_DEF0);
        add_row(v, 1'b0);
        // A zero byte ends a short name early.
        v = short_entry("AB CD   EXE", 8'h00, 32'h2, 32'h3);
        v[23:16] = 8'h00;
        add_row(v, 1'b0);
        // Deleted, volume label and dot entries produce nothing.
        v = short_entry("XDELETEDTXT", 8'h20, 32'h5, 32'h5);
        v[7:0] = B0_DELETED;
        add_row(v, 1'b0);
        add_row(short_entry("VOLUME     ", 8'h08, 32'h0, 32'h0), 1'b0);
        add_row(short_entry(".          ", 8'h10, 32'h7, 32'h0), 1'b0);
        // Two-piece long name with a character above 7F, then its short entry.
        c = utf16_of("fileXnameXXX");
        c[4*16 +: 16] = 16'h00E9;
        add_row(lfn_entry(8'h42, utf16_of("ok")), 1'b0);
        add_row(lfn_entry(8'h01, c), 1'b0);
        add_row(short_entry("FILENA~1TXT", 8'h20, 32'hA, 32'hB), 1'b0);
        // A piece with no open long name writes nothing; sequence 0 and 21 write nothing.
        add_row(lfn_entry(8'h01, utf16_of("stray")), 1'b0);
        add_row(lfn_entry(8'h40, utf16_of("zero")), 1'b0);
        add_row(lfn_entry(8'h55, utf16_of("tooHigh")), 1'b0);
        add_row(short_entry("EMPTYLFN   ", 8'h00, 32'hC, 32'hD), 1'b0);
        // All-ones entry counts as a label and is skipped.
        add_row({256{1'b1}}, 1'b0);
        // Longest name: all 20 slots full, cut to 255 characters over 32 chunks.
        for (int s = SLOT_MAX; s >= 1; s--) begin
            for (int i = 0; i < 13; i++) c[i*16 +: 16] = 16'("a") + 16'((s + i) % 26);
            add_row(lfn_entry(8'(s) | ((s == SLOT_MAX) ? LFN_FIRST : 8'h00), c), 1'b0);
        end
        add_row(short_entry("LONGNAMETXT", 8'h20, 32'hE, 32'hF), 1'b0);
        add_typed('0, 1'b0, end_word(7));

        foreach (directed_rows[r])
            send_entry(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want,
                       1'b0);

        // Fill the list to its limit so that later entries are dropped.
        send_random(pack_entry(random_short(1'b1), 1'b1), 1'b0);
        for (int k = 0; k < LIST_MAX + 4; k++)
            send_random(pack_entry(random_short(1'b1), 1'b0), $urandom_range(0, 2) == 0);

        // Hold off until the parser has delivered everything it owes.
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(negedge aclk);

        // Random part: mostly well-formed long-name sequences, with noise mixed in.
        calm = 1'b0;
        while (items_sent < TARGET_ITEMS) begin
            if ($urandom_range(0, 15) == 0) calm = ~calm;
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                pieces = ($urandom_range(0, 15) == 0) ? $urandom_range(4, SLOT_MAX)
                                                       : $urandom_range(1, 3);
                for (int s = pieces; s >= 1; s--) begin
                    v = lfn_entry(8'(s) | ((s == pieces) ? LFN_FIRST : 8'h00),
                                  random_chars());
                    if ($urandom_range(0, 19) == 0) v[7:0] = 8'($urandom);
                    if ($urandom_range(0, 24) != 0)
                        send_random(pack_entry(v, $urandom_range(0, 39) == 0), calm);
                end
                send_random(pack_entry(random_short(1'b0), 1'b0), calm);
            end else if (pick < 72) begin
                send_random(pack_entry(random_short(1'b0), $urandom_range(0, 9) == 0), calm);
            end else if (pick < 78) begin
                v = random_short(1'b0);
                v[7:0] = B0_DELETED;
                send_random(pack_entry(v, 1'b0), calm);
            end else if (pick < 84) begin
                v = random_short(1'b0);
                if ($urandom_range(0, 1)) v[95:88] = v[95:88] | ATTR_LABEL;
                else v[7:0] = ".";
                send_random(pack_entry(v, 1'b0), calm);
            end else if (pick < 94) begin
                v = {$urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom};
                send_random(pack_entry(v, 1'($urandom)), calm);
            end else begin
                v = random_short(1'b0);
                v[7:0] = B0_END;
                send_random(pack_entry(v, 1'b0), calm);
                send_random(pack_entry(random_short(1'b1), 1'b1), calm);
            end
        end
        s_valid <= 1'b0;

        while (pending_words.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (errors == 0 && pending_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
